FILE: src/ftdt_pkg.sv
// Shared constants, types and helper functions of the fixed-point to decimal text unit.
`default_nettype none

package ftdt_pkg;

	// Default sizes of the fixed-point input and of the fraction text.
	localparam int INT_BITS_DEF     = 16;
	localparam int FRAC_BITS_DEF    = 16;
	localparam int MAX_DECIMALS_DEF = 4;

	// Fixed widths of the ports.
	localparam int VALUE_W = 32;
	localparam int DP_W    = 3;
	localparam int CHAR_W  = 7;

	// ASCII codes that the unit emits.
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_POINT = 7'h2E;

	// Control of the fraction digit unit.
	typedef struct packed {
		logic load;
		logic step;
	} frac_ctrl_t;

	// Number of decimal digits needed for the largest value of a bits-wide integer.
	function automatic int dec_digits(input int bits);
		longint m;
		int     n;
		int     i;
		m = (longint'(1) << bits) - 1;
		n = 1;
		for (i = 0; i < 24; i++) begin
			if (m >= 10) begin
				m = m / 10;
				n = n + 1;
			end
		end
		return n;
	endfunction

endpackage

`default_nettype wire

FILE: src/ftdt_dabble.sv
// Iterative binary to BCD converter: one shift-and-add-three step per cycle.
`default_nettype none

module ftdt_dabble #(
	parameter int INT_BITS = ftdt_pkg::INT_BITS_DEF,
	parameter int NUM_DIG  = ftdt_pkg::dec_digits(ftdt_pkg::INT_BITS_DEF)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [INT_BITS-1:0]   bin,
	output logic                       done,
	output logic [4*NUM_DIG-1:0]       bcd
);

	localparam int CNT_W = $clog2(INT_BITS + 1);

	logic [INT_BITS-1:0]  bin_q;
	logic [4*NUM_DIG-1:0] bcd_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [4*NUM_DIG-1:0] adj;

	// Add three to every digit of five or more before the shift.
	always_comb begin
		for (int i = 0; i < NUM_DIG; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// Step counter: one input bit enters the digits each cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(INT_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Shift register of the binary input and the BCD digits.
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			bin_q <= {bin_q[INT_BITS-2:0], 1'b0};
			bcd_q <= {adj[4*NUM_DIG-2:0], bin_q[INT_BITS-1]};
		end
	end

	assign done = (cnt_q == '0);
	assign bcd  = bcd_q;

endmodule

`default_nettype wire

FILE: src/ftdt_frac.sv
// Fraction digit unit: multiplies the fraction by ten and yields one digit per step.
`default_nettype none

module ftdt_frac #(
	parameter int FRAC_BITS = ftdt_pkg::FRAC_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire ftdt_pkg::frac_ctrl_t ctrl,
	input  wire logic [FRAC_BITS-1:0] frac,
	output logic [3:0]                digit
);

	logic [FRAC_BITS-1:0] frac_q;
	logic [FRAC_BITS+3:0] prod;

	// Times ten as eight plus two; the top four bits are the next digit.
	assign prod  = ({4'b0, frac_q} << 3) + ({4'b0, frac_q} << 1);
	assign digit = prod[FRAC_BITS+3:FRAC_BITS];

	// The remaining fraction is kept for the next digit.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			frac_q <= frac;
		end else if (ctrl.step) begin
			frac_q <= prod[FRAC_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: src/fixed_to_decimal_text_unit.sv
// Top level of the unit that renders an unsigned fixed-point number as decimal text.
//
// Usage: an input beat on in_valid/in_stall carries one unsigned fixed-point value
// (INT_BITS integer bits over FRAC_BITS fraction bits). The unit answers with a run of
// ASCII output beats on out_valid/out_stall: the integer digits without leading zeros
// (a lone '0' for a zero integer part), then, when the fraction digit count is nonzero,
// a '.' and exactly that many truncated fraction digits. The final beat has last set.
// The fraction digit count is written through cfg_wr_en/cfg_wr_data while the unit is
// idle; values above MAX_DECIMALS count as MAX_DECIMALS.
// Timing: after acceptance the iterative BCD converter takes one input bit per cycle and
// then hands the digits over; after that one character leaves per cycle while the output
// is not stalled, the fraction digits coming from a multiply-by-ten unit stepped once
// per digit. A new value (for instance a full Q16.16 number with four places) is only
// accepted once every character of the previous one has entered the output register.
// in_stall stays high from acceptance until the last character enters the output
// register. A stall on the output holds the register and pauses the sequencer.
// Reset clears the sequencer, the output valid and the fraction digit count (to zero).
`default_nettype none

module fixed_to_decimal_text_unit #(
	parameter int INT_BITS     = ftdt_pkg::INT_BITS_DEF,
	parameter int FRAC_BITS    = ftdt_pkg::FRAC_BITS_DEF,
	parameter int MAX_DECIMALS = ftdt_pkg::MAX_DECIMALS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [ftdt_pkg::DP_W-1:0]   cfg_wr_data,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [ftdt_pkg::VALUE_W-1:0] value,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [ftdt_pkg::CHAR_W-1:0]      character,
	output logic                             last
);

	localparam int NUM_DIG = ftdt_pkg::dec_digits(INT_BITS);
	localparam int IDX_W   = $clog2(NUM_DIG);
	localparam int W       = INT_BITS + FRAC_BITS;
	localparam int DP_W    = ftdt_pkg::DP_W;
	localparam int CHAR_W  = ftdt_pkg::CHAR_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CONV  = 3'd1;
	localparam logic [2:0] ST_INT   = 3'd2;
	localparam logic [2:0] ST_POINT = 3'd3;
	localparam logic [2:0] ST_FRAC  = 3'd4;

	logic [2:0]                        state_q, state_d;
	logic [DP_W-1:0]                   frac_places_q;
	logic [DP_W-1:0]                   places_q, places_d, places_clamp;
	logic [DP_W-1:0]                   fcnt_q, fcnt_d;
	logic [IDX_W-1:0]                  dig_idx_q, dig_idx_d, lead_idx;
	logic                              out_valid_q;
	logic [CHAR_W-1:0]                 char_q;
	logic                              last_q;
	logic                              out_ok;
	logic                              emit;
	logic [CHAR_W-1:0]                 emit_char;
	logic                              emit_last;
	logic                              dab_start;
	logic                              dab_done;
	logic [4*NUM_DIG-1:0]              bcd;
	logic [3:0]                        int_digit;
	logic [3:0]                        frac_digit;
	ftdt_pkg::frac_ctrl_t              frac_ctrl;
	logic [W+ftdt_pkg::VALUE_W-1:0]    value_ext;

	// Zero-extend so that integer bits beyond the port read as zero.
	assign value_ext = {{W{1'b0}}, value};

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_places_q <= '0;
		end else if (cfg_wr_en) begin
			frac_places_q <= cfg_wr_data;
		end
	end

	assign places_clamp = (frac_places_q > DP_W'(MAX_DECIMALS)) ?
		DP_W'(MAX_DECIMALS) : frac_places_q;

	ftdt_dabble #(
		.INT_BITS (INT_BITS),
		.NUM_DIG  (NUM_DIG)
	) u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dab_start),
		.bin    (value_ext[W-1:FRAC_BITS]),
		.done   (dab_done),
		.bcd    (bcd)
	);

	ftdt_frac #(
		.FRAC_BITS (FRAC_BITS)
	) u_frac (
		.clk   (clk),
		.ctrl  (frac_ctrl),
		.frac  (value_ext[FRAC_BITS-1:0]),
		.digit (frac_digit)
	);

	// Position of the most significant nonzero digit, zero when all are zero.
	always_comb begin
		lead_idx = '0;
		for (int i = 0; i < NUM_DIG; i++) begin
			if (bcd[4*i +: 4] != 4'd0) begin
				lead_idx = IDX_W'(i);
			end
		end
	end

	assign int_digit = bcd[4*dig_idx_q +: 4];
	assign out_ok    = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);

	// Sequencer: convert, then emit integer digits, point and fraction digits.
	always_comb begin
		state_d        = state_q;
		places_d       = places_q;
		fcnt_d         = fcnt_q;
		dig_idx_d      = dig_idx_q;
		dab_start      = 1'b0;
		frac_ctrl.load = 1'b0;
		frac_ctrl.step = 1'b0;
		emit           = 1'b0;
		emit_char      = ftdt_pkg::CHAR_ZERO;
		emit_last      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					dab_start      = 1'b1;
					frac_ctrl.load = 1'b1;
					places_d       = places_clamp;
					state_d        = ST_CONV;
				end
			end
			ST_CONV: begin
				if (dab_done) begin
					dig_idx_d = lead_idx;
					state_d   = ST_INT;
				end
			end
			ST_INT: begin
				if (out_ok) begin
					emit      = 1'b1;
					emit_char = ftdt_pkg::CHAR_ZERO + {3'b0, int_digit};
					emit_last = (dig_idx_q == '0) && (places_q == '0);
					if (dig_idx_q == '0) begin
						state_d = (places_q != '0) ? ST_POINT : ST_IDLE;
					end else begin
						dig_idx_d = dig_idx_q - 1'b1;
					end
				end
			end
			ST_POINT: begin
				if (out_ok) begin
					emit      = 1'b1;
					emit_char = ftdt_pkg::CHAR_POINT;
					fcnt_d    = places_q;
					state_d   = ST_FRAC;
				end
			end
			ST_FRAC: begin
				if (out_ok) begin
					emit           = 1'b1;
					emit_char      = ftdt_pkg::CHAR_ZERO + {3'b0, frac_digit};
					emit_last      = (fcnt_q == DP_W'(1));
					frac_ctrl.step = 1'b1;
					fcnt_d         = fcnt_q - 1'b1;
					if (fcnt_q == DP_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer state and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			places_q  <= '0;
			fcnt_q    <= '0;
			dig_idx_q <= '0;
		end else begin
			state_q   <= state_d;
			places_q  <= places_d;
			fcnt_q    <= fcnt_d;
			dig_idx_q <= dig_idx_d;
		end
	end

	// Output register valid: set by a new beat, cleared once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

`default_nettype wire
